### src/kdl_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the key debouncer with long-press detection.
// Used by kdl_lane, kdl_merge and the top level; depends on nothing else.
package kdl_pkg;

    localparam logic [1:0] ST_UP    = 2'd0;
    localparam logic [1:0] ST_PRESS = 2'd1;
    localparam logic [1:0] ST_LONG  = 2'd2;

    localparam logic [1:0] TM_IDLE  = 2'd0;
    localparam logic [1:0] TM_DEB   = 2'd1;
    localparam logic [1:0] TM_LONG  = 2'd2;

    localparam logic [1:0] REG_DEBOUNCE = 2'd0;
    localparam logic [1:0] REG_LONG     = 2'd1;
    localparam logic [1:0] REG_POLARITY = 2'd2;
    localparam logic [1:0] REG_KEYCOUNT = 2'd3;

    localparam int        CFG_W        = 16;
    localparam int        LEVEL_W      = 8;
    localparam logic [15:0] DEBOUNCE_RESET = 16'd10;
    localparam logic [15:0] LONG_RESET     = 16'd1000;
    localparam logic [7:0]  POLARITY_RESET = 8'd0;
    localparam logic [3:0]  KEYCOUNT_RESET = 4'd8;

    typedef struct packed {
        logic       hit;
        logic [1:0] state;
    } event_t;

endpackage

### src/kdl_lane.sv
`timescale 1ns / 1ps
// One key: edge detector, debounce and long-press timer, three-state machine.
// Depends on kdl_pkg for state and timer mode codes and the event type.
module kdl_lane #(
    parameter int TIMER_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic                  level,
    input  logic                  pressed,
    input  logic [TIMER_BITS-1:0] deb_load,
    input  logic [TIMER_BITS-1:0] long_load,
    output kdl_pkg::event_t       ev
);

    logic [1:0]            state_reg, state_next;
    logic [1:0]            mode_reg, mode_next;
    logic [TIMER_BITS-1:0] count_reg, count_next;
    logic                  armed_reg, armed_next;
    logic                  prev_reg;

    always_comb
    begin
        logic                  watched;
        logic                  at_pressed;
        logic [TIMER_BITS-1:0] dec;
        state_next = state_reg;
        mode_next  = mode_reg;
        count_next = count_reg;
        armed_next = armed_reg;
        watched    = (state_reg == kdl_pkg::ST_UP) ? pressed : ~pressed;
        at_pressed = (level == pressed);
        dec        = count_reg - TIMER_BITS'(1);
        if (armed_reg && (prev_reg != level) && (level == watched))
        begin
            armed_next = 1'b0;
            mode_next  = kdl_pkg::TM_DEB;
            count_next = deb_load;
        end
        else if (mode_reg != kdl_pkg::TM_IDLE)
        begin
            count_next = dec;
            if (dec == '0)
            begin
                mode_next = kdl_pkg::TM_IDLE;
                case (state_reg)
                    kdl_pkg::ST_UP:
                    begin
                        if (at_pressed && mode_reg == kdl_pkg::TM_DEB)
                        begin
                            state_next = kdl_pkg::ST_PRESS;
                            mode_next  = kdl_pkg::TM_LONG;
                            count_next = long_load;
                        end
                        armed_next = 1'b1;
                    end
                    kdl_pkg::ST_PRESS:
                    begin
                        if (at_pressed && mode_reg == kdl_pkg::TM_LONG)
                        begin
                            state_next = kdl_pkg::ST_LONG;
                        end
                        else if (!at_pressed && mode_reg == kdl_pkg::TM_DEB)
                        begin
                            state_next = kdl_pkg::ST_UP;
                            armed_next = 1'b1;
                        end
                        else
                        begin
                            armed_next = 1'b1;
                            mode_next  = kdl_pkg::TM_LONG;
                            count_next = long_load;
                        end
                    end
                    default:
                    begin
                        if (!at_pressed && mode_reg == kdl_pkg::TM_DEB)
                        begin
                            state_next = kdl_pkg::ST_UP;
                        end
                        armed_next = 1'b1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= kdl_pkg::ST_UP;
            mode_reg  <= kdl_pkg::TM_IDLE;
            count_reg <= '0;
            armed_reg <= 1'b1;
            prev_reg  <= ~kdl_pkg::POLARITY_RESET[0];
        end
        else if (step)
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            count_reg <= count_next;
            armed_reg <= armed_next;
            prev_reg  <= level;
        end
    end

    assign ev.hit   = step && (state_next != state_reg);
    assign ev.state = state_next;

endmodule

### src/kdl_merge.sv
`timescale 1ns / 1ps
// Collects the state changes of one tick and sends them out one word at a time,
// lowest key first, through a registered output. Depends on kdl_pkg.
module kdl_merge #(
    parameter int NUM_KEYS = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   accept,
    input  kdl_pkg::event_t        ev [NUM_KEYS],
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [2:0]             out_index,
    output logic [1:0]             out_state,
    output logic                   out_last
);

    localparam int IW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

    logic [NUM_KEYS-1:0] mask_reg, mask_next;
    logic [1:0]          pend_state_reg [NUM_KEYS];
    logic                valid_reg;
    logic [2:0]          index_reg;
    logic [1:0]          state_reg;
    logic                last_reg;

    logic [NUM_KEYS-1:0] rest;
    logic [IW-1:0]       sel;
    logic [2:0]          sel_key;
    logic                load_out, pop, single;

    always_comb
    begin
        sel     = '0;
        sel_key = '0;
        for (int i = NUM_KEYS - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                sel     = IW'(i);
                sel_key = 3'(i);
            end
        end
    end

    assign rest     = mask_reg & (mask_reg - NUM_KEYS'(1));
    assign single   = (rest == '0);
    assign load_out = !valid_reg || out_ready;
    assign pop      = load_out && (mask_reg != '0);
    assign in_ready = (mask_reg == '0) || (pop && single);

    always_comb
    begin
        mask_next = pop ? rest : mask_reg;
        if (accept)
        begin
            for (int i = 0; i < NUM_KEYS; i++)
            begin
                mask_next[i] = ev[i].hit;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg <= mask_next;
            if (pop)
            begin
                valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < NUM_KEYS; i++)
            begin
                pend_state_reg[i] <= ev[i].state;
            end
        end
        if (pop)
        begin
            index_reg <= sel_key;
            state_reg <= pend_state_reg[sel];
            last_reg  <= single;
        end
    end

    assign out_valid = valid_reg;
    assign out_index = index_reg;
    assign out_state = state_reg;
    assign out_last  = last_reg;

endmodule

### src/key_debounce_long_press_top.sv
`timescale 1ns / 1ps
// Channel | Dir | Handshake         | Content
// s_*     | in  | s_tvalid/s_tready | tdata[7:0] key_levels
// m_*     | out | m_tvalid/m_tready | tdata[2:0] key_index, [4:3] key state; tlast last
// cfg_*   | in  | cfg_we            | cfg_addr register index, cfg_wdata value
// A tick is taken in the cycle it arrives whenever no earlier events are waiting.
// A tick that changes k keys yields k words on consecutive cycles when m_tready is held.
// The next tick is taken in the cycle the final waiting event moves to the output register.
// Reset restores the register defaults and puts every key in the up state at once.
// Stalls on m_tready hold the output word and, once events queue, hold s_tready low.
// Top level of the key debouncer; depends on kdl_pkg, kdl_lane and kdl_merge.
module key_debounce_long_press_top #(
    parameter int NUM_KEYS   = 8,
    parameter int TIMER_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] key_levels
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [2:0] key_index, [4:3] key state, [7:5] zero
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);

    localparam logic [31:0] TMAX = 32'((64'd1 << TIMER_BITS) - 64'd1);

    logic [15:0] deb_reg;
    logic [15:0] long_reg;
    logic [7:0]  pol_reg;
    logic [3:0]  kcnt_reg;

    logic                  accept;
    logic [TIMER_BITS-1:0] deb_load, long_load;
    kdl_pkg::event_t       ev [NUM_KEYS];
    logic [2:0]            out_index;
    logic [1:0]            out_state;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deb_reg  <= kdl_pkg::DEBOUNCE_RESET;
            long_reg <= kdl_pkg::LONG_RESET;
            pol_reg  <= kdl_pkg::POLARITY_RESET;
            kcnt_reg <= kdl_pkg::KEYCOUNT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                kdl_pkg::REG_DEBOUNCE: deb_reg  <= cfg_wdata;
                kdl_pkg::REG_LONG:     long_reg <= cfg_wdata;
                kdl_pkg::REG_POLARITY: pol_reg  <= cfg_wdata[7:0];
                kdl_pkg::REG_KEYCOUNT: kcnt_reg <= cfg_wdata[3:0];
                default:               deb_reg  <= deb_reg;
            endcase
        end
    end

    always_comb
    begin
        logic [31:0] d, l;
        d = {16'd0, deb_reg};
        l = {16'd0, long_reg};
        if (d == 32'd0)
        begin
            d = 32'd1;
        end
        else if (d > TMAX)
        begin
            d = TMAX;
        end
        if (l == 32'd0)
        begin
            l = 32'd1;
        end
        else if (l > TMAX)
        begin
            l = TMAX;
        end
        deb_load  = d[TIMER_BITS-1:0];
        long_load = l[TIMER_BITS-1:0];
    end

    assign accept = s_tvalid && s_tready;

    for (genvar i = 0; i < NUM_KEYS; i++)
    begin : g_lane
        logic lvl, pol, en;
        if (i < kdl_pkg::LEVEL_W)
        begin : g_pin
            assign lvl = s_tdata[i];
            assign pol = pol_reg[i];
        end
        else
        begin : g_nopin
            assign lvl = 1'b0;
            assign pol = 1'b0;
        end
        assign en = (32'(i) < {28'd0, kcnt_reg});

        kdl_lane #(
            .TIMER_BITS (TIMER_BITS)
        ) u_lane (
            .clk       (clk),
            .rst_n     (rst_n),
            .step      (accept && en),
            .level     (lvl),
            .pressed   (pol),
            .deb_load  (deb_load),
            .long_load (long_load),
            .ev        (ev[i])
        );
    end

    kdl_merge #(
        .NUM_KEYS (NUM_KEYS)
    ) u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .ev        (ev),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_index (out_index),
        .out_state (out_state),
        .out_last  (m_tlast)
    );

    assign m_tdata = {3'b000, out_state, out_index};

endmodule

### src/kdl_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the key debouncer, attached to the top level by bind.
// Depends only on the top level's ports.
module kdl_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [7:0] s_tdata,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    // A stalled output word holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed while stalled");

    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[4:3] != 2'b11) && (m_tdata[7:5] == 3'b000))
        else $error("bad state code or padding");

    // Events of one tick leave back to back.
    a_burst: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("gap inside the events of one tick");

    // Input is held off only while events wait to be sent.
    a_backp: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |=> m_tvalid)
        else $error("input stalled with nothing to send");

    // An offered input word carries known key levels.
    a_known: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid |-> !$isunknown(s_tdata))
        else $error("unknown key levels on an offered input word");

endmodule

bind key_debounce_long_press_top kdl_checker u_kdl_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
